// ----- design/mmc_pkg.sv -----
`default_nettype none

package mmc_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int SIZE_W = 13;
    localparam int THR_W  = 11;

    // result queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 2);

    // register indexes
    localparam logic [1:0] REG_LINE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FIELD_HEIGHT = 2'd1;
    localparam logic [1:0] REG_THRESHOLD    = 2'd2;

    localparam logic [7:0] MASK_ON  = 8'hFF;
    localparam logic [7:0] MASK_OFF = 8'h00;

    typedef struct packed {
        logic emit_first;
        logic emit_second;
        logic left_mirror;
        logic up_mirror;
        logic last_row;
    } flags_t;

    typedef struct packed {
        flags_t     flags;
        logic [7:0] prev2;
        logic [7:0] prev;
        logic [7:0] top;
        logic [7:0] bot_first;
        logic [7:0] bot_second;
    } entry_t;

endpackage

`default_nettype wire

// ----- design/mmc_front.sv -----
`default_nettype none

module mmc_front (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire  [47:0]                 s_tdata,
    input  wire  [mmc_pkg::SIZE_W-1:0]  line_width,
    input  wire  [mmc_pkg::SIZE_W-1:0]  field_height,
    input  wire  [mmc_pkg::QCNT_W-1:0]  q_count,
    output logic                        q_push,
    output mmc_pkg::entry_t             q_entry
);
    import mmc_pkg::*;

    logic [23:0] line_mem [MAX_WIDTH];
    logic [23:0] rd_data_reg;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              field_seen_reg, field_seen_next;
    logic              valid_b_reg, valid_b_next;
    logic [COL_W-1:0]  addr_b_reg;
    logic [7:0]        top_b_reg, bot_b_reg;
    flags_t            flags_b_reg;
    logic [7:0]        bot_delay_reg, bot_delay_next;

    logic [SIZE_W-1:0] w_clamped, h_clamped;
    logic              accept, row_end, field_end, last_row, emit;
    logic [7:0]        top_and, bot_and;
    flags_t            flags_a;

    always_comb begin
        if (line_width < SIZE_W'(2)) begin
            w_clamped = SIZE_W'(2);
        end else if (line_width > SIZE_W'(MAX_WIDTH)) begin
            w_clamped = SIZE_W'(MAX_WIDTH);
        end else begin
            w_clamped = line_width;
        end
        if (field_height < SIZE_W'(2)) begin
            h_clamped = SIZE_W'(2);
        end else if (field_height > SIZE_W'(MAX_HEIGHT)) begin
            h_clamped = SIZE_W'(MAX_HEIGHT);
        end else begin
            h_clamped = field_height;
        end
    end

    assign s_tready = (q_count + QCNT_W'(valid_b_reg)) < QCNT_W'(QDEPTH);
    assign accept   = s_tvalid && s_tready;

    assign top_and   = s_tdata[7:0] & s_tdata[15:8] & s_tdata[23:16];
    assign bot_and   = s_tdata[31:24] & s_tdata[39:32] & s_tdata[47:40];
    assign row_end   = SIZE_W'(col_reg) >= (w_clamped - SIZE_W'(1));
    assign field_end = SIZE_W'(row_reg) >= (h_clamped - SIZE_W'(1));
    assign last_row  = (row_reg == '0);
    assign emit      = last_row ? field_seen_reg : 1'b1;

    always_comb begin
        flags_a.emit_first  = emit && (col_reg != '0);
        flags_a.emit_second = emit && row_end;
        flags_a.left_mirror = (col_reg == COL_W'(1));
        flags_a.up_mirror   = !last_row && (row_reg == ROW_W'(1));
        flags_a.last_row    = last_row;
    end

    always_comb begin
        col_next        = col_reg;
        row_next        = row_reg;
        field_seen_next = field_seen_reg;
        if (accept) begin
            if (row_end) begin
                col_next = '0;
                if (field_end) begin
                    row_next        = '0;
                    field_seen_next = 1'b1;
                end else begin
                    row_next = row_reg + ROW_W'(1);
                end
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
        valid_b_next   = accept;
        bot_delay_next = valid_b_reg ? rd_data_reg[7:0] : bot_delay_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            field_seen_reg <= 1'b0;
            valid_b_reg    <= 1'b0;
            bot_delay_reg  <= '0;
        end else begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            field_seen_reg <= field_seen_next;
            valid_b_reg    <= valid_b_next;
            bot_delay_reg  <= bot_delay_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_b_reg  <= col_reg;
            top_b_reg   <= top_and;
            bot_b_reg   <= bot_and;
            flags_b_reg <= flags_a;
        end
    end

    // line buffer: {row r-2, row r-1, bottom row r-1}, read before overwrite
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= line_mem[col_reg];
        end
        if (valid_b_reg) begin
            line_mem[addr_b_reg] <= {rd_data_reg[15:8], top_b_reg, bot_b_reg};
        end
    end

    assign q_push = valid_b_reg;

    always_comb begin
        q_entry.flags      = flags_b_reg;
        q_entry.prev2      = rd_data_reg[23:16];
        q_entry.prev       = rd_data_reg[15:8];
        q_entry.top        = top_b_reg;
        q_entry.bot_first  = bot_delay_reg;
        q_entry.bot_second = rd_data_reg[7:0];
    end

endmodule

`default_nettype wire

// ----- design/mmc_queue.sv -----
`default_nettype none

module mmc_queue (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         push,
    input  mmc_pkg::entry_t             push_entry,
    input  wire                         pop,
    output logic                        head_valid,
    output mmc_pkg::entry_t             head_entry,
    output logic [mmc_pkg::QCNT_W-1:0]  count
);
    import mmc_pkg::*;

    entry_t             slots [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_entry = slots[rd_ptr_reg];
    assign count      = count_reg;

endmodule

`default_nettype wire

// ----- design/mmc_back.sv -----
`default_nettype none

module mmc_back (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         head_valid,
    input  mmc_pkg::entry_t             head_entry,
    output logic                        pop,
    input  wire  [mmc_pkg::THR_W-1:0]   threshold,
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [7:0]                  m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser
);
    import mmc_pkg::*;

    typedef logic [2:0][2:0][7:0] win_t;   // [col][row], col 0 oldest

    win_t        win_reg, win_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [7:0]  pend_mask_reg;
    logic        pend_frame_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_mask_reg;
    logic        out_last_reg, out_user_reg;

    logic        out_free, has_result, load_head, load_pend;
    logic [1:0]  lc_first, up, dn;
    logic [7:0]  res_first, res_second;

    function automatic logic [7:0] decide(input win_t w, input logic [1:0] lc,
                                          input logic [1:0] cc, input logic [1:0] rc,
                                          input logic [1:0] up_r, input logic [1:0] dn_r,
                                          input logic [7:0] bot,
                                          input logic [THR_W-1:0] thr);
        logic [THR_W-1:0] sum;
        sum = THR_W'(w[lc][up_r]) + THR_W'(w[cc][up_r]) + THR_W'(w[rc][up_r])
            + THR_W'(w[lc][1])    + THR_W'(w[rc][1])
            + THR_W'(w[lc][dn_r]) + THR_W'(w[cc][dn_r]) + THR_W'(w[rc][dn_r]);
        if (w[cc][1] != 8'd0) begin
            return MASK_ON;
        end else if (bot == 8'd0) begin
            return MASK_OFF;
        end else begin
            return (sum >= thr) ? MASK_ON : MASK_OFF;
        end
    endfunction

    always_comb begin
        win_next[0]    = win_reg[1];
        win_next[1]    = win_reg[2];
        win_next[2][0] = head_entry.prev2;
        win_next[2][1] = head_entry.prev;
        win_next[2][2] = head_entry.top;
    end

    assign lc_first = head_entry.flags.left_mirror ? 2'd2 : 2'd0;
    assign up       = head_entry.flags.up_mirror   ? 2'd2 : 2'd0;
    assign dn       = head_entry.flags.last_row    ? 2'd0 : 2'd2;

    assign res_first  = decide(win_next, lc_first, 2'd1, 2'd2, up, dn,
                               head_entry.bot_first, threshold);
    assign res_second = decide(win_next, 2'd1, 2'd2, 2'd1, up, dn,
                               head_entry.bot_second, threshold);

    assign out_free   = !out_valid_reg || m_tready;
    assign has_result = head_entry.flags.emit_first || head_entry.flags.emit_second;
    assign pop        = head_valid && !pend_valid_reg && (!has_result || out_free);
    assign load_head  = pop && has_result;
    assign load_pend  = pend_valid_reg && out_free;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        if (load_pend) begin
            pend_valid_next = 1'b0;
        end else if (load_head) begin
            pend_valid_next = head_entry.flags.emit_first && head_entry.flags.emit_second;
        end
        if (load_head || load_pend) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (pop) begin
                win_reg <= win_next;
            end
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_pend) begin
            out_mask_reg <= pend_mask_reg;
            out_last_reg <= 1'b1;
            out_user_reg <= pend_frame_reg;
        end else if (load_head) begin
            if (head_entry.flags.emit_first) begin
                out_mask_reg <= res_first;
                out_last_reg <= !head_entry.flags.emit_second;
                out_user_reg <= 1'b0;
            end else begin
                out_mask_reg <= res_second;
                out_last_reg <= 1'b1;
                out_user_reg <= head_entry.flags.last_row;
            end
            pend_mask_reg  <= res_second;
            pend_frame_reg <= head_entry.flags.last_row;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_mask_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

// ----- design/motion_mask_and_combine_top.sv -----
`default_nettype none

// Motion mask combiner. Each input beat is one pixel position in raster order and carries
// three mask bytes of the top half field and three of the bottom half; each triple is ANDed.
// A result is 0xFF where the top AND is nonzero, 0x00 where the bottom AND is zero, and
// otherwise 0xFF when the eight top-AND neighbours of the 3x3 window sum to at least
// neighbour_threshold. Windows mirror about the border pixel. Results trail the input by one
// row and one pixel: the last row of a field comes out while row 0 of the next field goes in,
// and the first field's row 0 gives no results. m_tlast marks the last result caused by an
// input beat, m_tuser marks the last pixel of a field. The front end takes one beat per cycle
// while the queue has room and reads one 24-bit line buffer entry per beat (read, then written
// back in the following cycle); the back end shifts the window and gives one result per cycle
// while the output is not stalled, and the input beat at the end of each row causes two
// results. A four-entry queue between front and back absorbs that and output stalls.
// Line buffers hold no reset: results that read entries not yet written are undefined.
// Configuration: line_width at 0x0, field_height at 0x4, neighbour_threshold at 0x8; write
// only while idle.

module motion_mask_and_combine_top (
    input  wire         aclk,
    input  wire         aresetn,
    // config port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input pixels
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,    // cur_top, next_top, other_top, cur_bottom, next_bottom,
                                    // other_bottom
    // results
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,    // mask_value
    output logic        m_tlast,    // last_of_run
    output logic        m_tuser     // frame_end
);
    import mmc_pkg::*;

    logic [SIZE_W-1:0] line_width_reg, line_width_next;
    logic [SIZE_W-1:0] field_height_reg, field_height_next;
    logic [THR_W-1:0]  threshold_reg, threshold_next;
    logic              cfg_write;
    logic [1:0]        cfg_index;

    logic              q_push, q_pop, q_head_valid;
    entry_t            q_push_entry, q_head_entry;
    logic [QCNT_W-1:0] q_count;

    // register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_comb begin
        line_width_next   = line_width_reg;
        field_height_next = field_height_reg;
        threshold_next    = threshold_reg;
        if (cfg_write) begin
            case (cfg_index)
                REG_LINE_WIDTH:   line_width_next   = pwdata[SIZE_W-1:0];
                REG_FIELD_HEIGHT: field_height_next = pwdata[SIZE_W-1:0];
                REG_THRESHOLD:    threshold_next    = pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_LINE_WIDTH:   prdata = 32'(line_width_reg);
            REG_FIELD_HEIGHT: prdata = 32'(field_height_reg);
            REG_THRESHOLD:    prdata = 32'(threshold_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= SIZE_W'(720);
            field_height_reg <= SIZE_W'(240);
            threshold_reg    <= THR_W'(4);
        end else begin
            line_width_reg   <= line_width_next;
            field_height_reg <= field_height_next;
            threshold_reg    <= threshold_next;
        end
    end

    // front: counters, edge classification, line buffers
    mmc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .line_width   (line_width_reg),
        .field_height (field_height_reg),
        .q_count      (q_count),
        .q_push       (q_push),
        .q_entry      (q_push_entry)
    );

    // queue decouples the front from output backpressure
    mmc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry),
        .count      (q_count)
    );

    // back: 3x3 window, decision, output register
    mmc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry),
        .pop        (q_pop),
        .threshold  (threshold_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // queue never overfills
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    // credit check: a push always finds room
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_count < QCNT_W'(QDEPTH)))
        else $error("push into full queue");

    // the field-end result is always the last of its beat
    a_frame_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame end without last");

endmodule

`default_nettype wire
